FILE: rtl/core/mcbf_pkg.sv
// Shared types and constants for the multi-channel byte FIFO.
package mcbf_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int BUF_BYTES_DEF    = 256;
    localparam int MAX_READ_DEF     = 16;
    localparam int RESULT_CAP       = 16;

    localparam int OP_W      = 3;
    localparam int CH_FLD_W  = 3;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int MOVED_W   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 3'd0,
        OP_FREE  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_CLOSE = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD     = 2'd1,
        ST_NO_FREE = 2'd2,
        ST_EOS     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    // byte store port enables
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_store_ctl;

endpackage

FILE: rtl/core/mcbf_store.sv
// Byte store: single-port-write, single-port-read synchronous RAM.
module mcbf_store #(
    parameter int DEPTH = mcbf_pkg::NUM_CHANNELS_DEF * mcbf_pkg::BUF_BYTES_DEF
) (
    input  logic                        i_clk,
    input  mcbf_pkg::t_store_ctl        i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  logic [mcbf_pkg::BYTE_W-1:0] i_wr_data,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    output logic [mcbf_pkg::BYTE_W-1:0] o_rd_data
);

    logic [mcbf_pkg::BYTE_W-1:0] m_bytes [DEPTH];
    logic [mcbf_pkg::BYTE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            m_bytes[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= m_bytes[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/multi_channel_byte_fifo.sv
// Top level of the multi-channel byte FIFO: command decode, channel table, sequencer.
//
// Usage: a command beat is taken on a rising edge with start high and busy low.
// Opcodes: alloc, free, write byte, read, close end. Results come back one per
// cycle on the o_ ports, each marked by o_strobe for exactly one cycle; the
// receiver cannot hold them off, so it must take every strobed beat.
// Results: for alloc, free, close, a burst-ending write, a failed or empty read
// or a bad opcode, the result is registered onto the ports once the command is
// latched and executed. A read of n bytes reads each byte from the byte store,
// then registers it onto the ports, back to back, last byte flagged with
// o_last. Writes without burst_end give no result. Each command reads its
// channel's pointer word from the pointer RAM, then acts and writes it back; a
// read then does one byte store read per cycle, busy high until its last byte
// is registered. The next command may be given while the previous result is
// still on the output registers.
// Reset (synchronous, active low) closes every channel and clears the burst
// tally and fault; pointer and byte RAMs are not cleared, since alloc sets a
// channel's pointers before any use.
module multi_channel_byte_fifo #(
    parameter int NUM_CHANNELS = mcbf_pkg::NUM_CHANNELS_DEF,
    parameter int BUF_BYTES    = mcbf_pkg::BUF_BYTES_DEF,
    parameter int MAX_READ     = mcbf_pkg::MAX_READ_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mcbf_pkg::OP_W-1:0]     i_opcode,
    input  logic [mcbf_pkg::CH_FLD_W-1:0] i_channel,
    input  logic [mcbf_pkg::BYTE_W-1:0]   i_wr_byte,
    input  logic                          i_burst_end,
    input  logic [mcbf_pkg::LEN_W-1:0]    i_read_len,
    input  logic                          i_which_end,
    output logic                          o_strobe,
    output logic [mcbf_pkg::STATUS_W-1:0] o_status,
    output logic [mcbf_pkg::CH_FLD_W-1:0] o_channel_out,
    output logic [mcbf_pkg::BYTE_W-1:0]   o_rd_byte,
    output logic                          o_byte_valid,
    output logic [mcbf_pkg::MOVED_W-1:0]  o_moved,
    output logic                          o_last
);

    localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int PTR_W  = $clog2(BUF_BYTES);
    localparam int FILL_W = $clog2(BUF_BYTES + 1);
    localparam int DEPTH  = NUM_CHANNELS * BUF_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = mcbf_pkg::LEN_W;
    localparam int CMP_W  = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int RD_LIM = (MAX_READ < mcbf_pkg::RESULT_CAP) ? MAX_READ
                                                              : mcbf_pkg::RESULT_CAP;
    localparam int PW_W   = 2 * PTR_W + FILL_W;
    localparam int MV_W   = mcbf_pkg::MOVED_W;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(BUF_BYTES - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // ---------------- state ----------------
    mcbf_pkg::t_state r_state, n_state;

    logic [NUM_CHANNELS-1:0] r_in_use,  n_in_use;
    logic [NUM_CHANNELS-1:0] r_rd_open, n_rd_open;
    logic [NUM_CHANNELS-1:0] r_wr_open, n_wr_open;
    logic [MV_W-1:0]         r_tally,   n_tally;
    logic                    r_fault,   n_fault;

    // latched command
    logic [mcbf_pkg::OP_W-1:0]     r_op;
    logic [mcbf_pkg::CH_FLD_W-1:0] r_ch;
    logic [mcbf_pkg::BYTE_W-1:0]   r_byte;
    logic                          r_bend;
    logic [LEN_W-1:0]              r_len;
    logic                          r_end;

    // read sequencer
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [LEN_W-1:0]  r_n,    n_n;
    logic [LEN_W-1:0]  r_done, n_done;

    // pointer RAM: {head, tail, fill} per channel
    logic [PW_W-1:0] m_ptr [NUM_CHANNELS];
    logic [PW_W-1:0] r_ptr_q;
    logic            ptr_we;
    logic [CH_W-1:0] ptr_waddr;
    logic [PW_W-1:0] ptr_wdata;

    // output registers
    logic                          r_strobe, n_strobe;
    logic [mcbf_pkg::STATUS_W-1:0] r_status, n_status;
    logic [mcbf_pkg::CH_FLD_W-1:0] r_chout,  n_chout;
    logic [mcbf_pkg::BYTE_W-1:0]   r_rbyte,  n_rbyte;
    logic                          r_bvalid, n_bvalid;
    logic [MV_W-1:0]               r_moved,  n_moved;
    logic                          r_last,   n_last;

    // byte store
    mcbf_pkg::t_store_ctl        st_ctl;
    logic [ADDR_W-1:0]           st_waddr;
    logic [ADDR_W-1:0]           st_raddr;
    logic [mcbf_pkg::BYTE_W-1:0] st_rdata;

    // ---------------- decode helpers ----------------
    logic                 accept;
    logic [CH_W+2:0]      in_ch_ext, r_ch_ext;
    logic [CH_W-1:0]      in_idx, r_idx;
    logic                 in_range, usable;
    logic [PTR_W-1:0]     head_q, tail_q;
    logic [FILL_W-1:0]    fill_q;
    logic [ADDR_W-1:0]    base;
    logic [LEN_W-1:0]     len_c, n_take, done_inc;
    logic [MV_W-1:0]      tally_inc;
    logic                 alloc_found;
    logic [CH_W-1:0]      alloc_grant;
    logic [CH_W+2:0]      grant_ext;

    assign busy      = (r_state != mcbf_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign in_ch_ext = {{CH_W{1'b0}}, i_channel};
    assign in_idx    = in_ch_ext[CH_W-1:0];
    assign r_ch_ext  = {{CH_W{1'b0}}, r_ch};
    assign r_idx     = r_ch_ext[CH_W-1:0];
    assign in_range  = ({4'd0, r_ch} < 7'(NUM_CHANNELS));
    assign usable    = in_range && r_in_use[r_idx];

    assign head_q = r_ptr_q[PW_W-1 -: PTR_W];
    assign tail_q = r_ptr_q[FILL_W +: PTR_W];
    assign fill_q = r_ptr_q[FILL_W-1:0];

    assign base      = ADDR_W'(r_idx) * ADDR_W'(BUF_BYTES);
    assign len_c     = (r_len > LEN_W'(RD_LIM)) ? LEN_W'(RD_LIM) : r_len;
    assign n_take    = (CMP_W'(fill_q) < CMP_W'(len_c)) ? LEN_W'(fill_q) : len_c;
    assign done_inc  = r_done + LEN_W'(1);
    assign tally_inc = (r_tally == {MV_W{1'b1}}) ? r_tally : r_tally + MV_W'(1);
    assign grant_ext = {3'b000, alloc_grant};

    // lowest free channel
    always_comb begin
        alloc_found = 1'b0;
        alloc_grant = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (!r_in_use[i]) begin
                alloc_found = 1'b1;
                alloc_grant = CH_W'(i);
            end
        end
    end

    // ---------------- pointer RAM ----------------
    always_ff @(posedge i_clk) begin
        if (ptr_we) begin
            m_ptr[ptr_waddr] <= ptr_wdata;
        end
        if (accept) begin
            r_ptr_q <= m_ptr[in_idx];
        end
    end

    // ---------------- byte store ----------------
    mcbf_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (st_ctl),
        .i_wr_addr (st_waddr),
        .i_wr_data (r_byte),
        .i_rd_addr (st_raddr),
        .o_rd_data (st_rdata)
    );

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mcbf_pkg::S_IDLE;
            r_in_use  <= '0;
            r_rd_open <= '0;
            r_wr_open <= '0;
            r_tally   <= '0;
            r_fault   <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_in_use  <= n_in_use;
            r_rd_open <= n_rd_open;
            r_wr_open <= n_wr_open;
            r_tally   <= n_tally;
            r_fault   <= n_fault;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_opcode;
            r_ch   <= i_channel;
            r_byte <= i_wr_byte;
            r_bend <= i_burst_end;
            r_len  <= i_read_len;
            r_end  <= i_which_end;
        end
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_fill   <= n_fill;
        r_n      <= n_n;
        r_done   <= n_done;
        r_status <= n_status;
        r_chout  <= n_chout;
        r_rbyte  <= n_rbyte;
        r_bvalid <= n_bvalid;
        r_moved  <= n_moved;
        r_last   <= n_last;
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state   = r_state;
        n_in_use  = r_in_use;
        n_rd_open = r_rd_open;
        n_wr_open = r_wr_open;
        n_tally   = r_tally;
        n_fault   = r_fault;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_n       = r_n;
        n_done    = r_done;

        ptr_we    = 1'b0;
        ptr_waddr = r_idx;
        ptr_wdata = r_ptr_q;

        st_ctl    = '0;
        st_waddr  = base + ADDR_W'(tail_q);
        st_raddr  = base + ADDR_W'(head_q);

        n_strobe  = 1'b0;
        n_status  = mcbf_pkg::ST_OK;
        n_chout   = r_ch;
        n_rbyte   = '0;
        n_bvalid  = 1'b0;
        n_moved   = '0;
        n_last    = 1'b1;

        case (r_state)
            mcbf_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = mcbf_pkg::S_EXEC;
                end
            end

            mcbf_pkg::S_EXEC: begin
                n_state  = mcbf_pkg::S_IDLE;
                n_strobe = 1'b1;
                case (mcbf_pkg::t_opcode'(r_op))
                    mcbf_pkg::OP_ALLOC: begin
                        if (alloc_found) begin
                            n_in_use[alloc_grant]  = 1'b1;
                            n_rd_open[alloc_grant] = 1'b1;
                            n_wr_open[alloc_grant] = 1'b1;
                            ptr_we    = 1'b1;
                            ptr_waddr = alloc_grant;
                            ptr_wdata = '0;
                            n_chout   = grant_ext[2:0];
                        end else begin
                            n_status = mcbf_pkg::ST_NO_FREE;
                            n_chout  = '0;
                        end
                    end

                    mcbf_pkg::OP_FREE: begin
                        if (in_range) begin
                            n_in_use[r_idx] = 1'b0;
                        end else begin
                            n_status = mcbf_pkg::ST_BAD;
                        end
                    end

                    mcbf_pkg::OP_WRITE: begin
                        if (!usable || !r_wr_open[r_idx]) begin
                            n_fault = 1'b1;
                        end else if (fill_q < FILL_W'(BUF_BYTES)) begin
                            st_ctl.wr_en = 1'b1;
                            ptr_we    = 1'b1;
                            ptr_wdata = {head_q, adv(tail_q), fill_q + FILL_W'(1)};
                            n_tally   = tally_inc;
                        end
                        // only the burst's closing beat reports
                        n_strobe = r_bend;
                        if (r_bend) begin
                            if (n_fault) begin
                                n_status = mcbf_pkg::ST_BAD;
                            end else begin
                                n_moved = n_tally;
                            end
                            n_tally = '0;
                            n_fault = 1'b0;
                        end
                    end

                    mcbf_pkg::OP_READ: begin
                        if (!usable || !r_rd_open[r_idx]) begin
                            n_status = mcbf_pkg::ST_BAD;
                        end else if (n_take == '0) begin
                            n_status = r_wr_open[r_idx] ? mcbf_pkg::ST_OK
                                                        : mcbf_pkg::ST_EOS;
                        end else begin
                            // first byte fetch; results stream from S_READ
                            n_strobe     = 1'b0;
                            st_ctl.rd_en = 1'b1;
                            n_head  = adv(head_q);
                            n_tail  = tail_q;
                            n_fill  = fill_q;
                            n_n     = n_take;
                            n_done  = '0;
                            n_state = mcbf_pkg::S_READ;
                        end
                    end

                    mcbf_pkg::OP_CLOSE: begin
                        if (!usable) begin
                            n_status = mcbf_pkg::ST_BAD;
                        end else begin
                            if (r_end) begin
                                n_wr_open[r_idx] = 1'b0;
                            end else begin
                                n_rd_open[r_idx] = 1'b0;
                            end
                            if (!n_rd_open[r_idx] && !n_wr_open[r_idx]) begin
                                n_in_use[r_idx] = 1'b0;
                            end
                        end
                    end

                    default: begin
                        n_status = mcbf_pkg::ST_BAD;
                    end
                endcase
            end

            mcbf_pkg::S_READ: begin
                // store data fetched last cycle goes out now
                n_strobe = 1'b1;
                n_rbyte  = st_rdata;
                n_bvalid = 1'b1;
                n_moved  = MV_W'(done_inc);
                n_last   = (done_inc == r_n);
                st_raddr = base + ADDR_W'(r_head);
                if (done_inc == r_n) begin
                    ptr_we    = 1'b1;
                    ptr_wdata = {r_head, r_tail, r_fill - FILL_W'(r_n)};
                    n_state   = mcbf_pkg::S_IDLE;
                end else begin
                    st_ctl.rd_en = 1'b1;
                    n_head = adv(r_head);
                    n_done = done_inc;
                end
            end

            default: begin
                n_state = mcbf_pkg::S_IDLE;
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_channel_out = r_chout;
    assign o_rd_byte     = r_rbyte;
    assign o_byte_valid  = r_bvalid;
    assign o_moved       = r_moved;
    assign o_last        = r_last;

endmodule

FILE: rtl/core/mcbf_checker.sv
// Port-level checker for the multi-channel byte FIFO, with its bind.
module mcbf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          o_strobe,
    input logic [mcbf_pkg::STATUS_W-1:0] o_status,
    input logic                          o_byte_valid,
    input logic [mcbf_pkg::MOVED_W-1:0]  o_moved,
    input logic                          o_last
);

    // a taken command always occupies the sequencer
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command beat");

    // mid-stream read beats only while the read is still running
    a_mid_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy && o_byte_valid)
        else $error("non-final result outside a read stream");

    // final result frees the block for the next command
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("block busy on final result");

    // data beats carry ok status and a nonzero count
    a_data_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_byte_valid |-> (o_status == mcbf_pkg::ST_OK) && (o_moved != '0))
        else $error("data beat with bad status or zero count");

    // read beats come back to back with a rising count
    a_stream_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe && o_byte_valid &&
                                (o_moved == $past(o_moved) + 16'd1))
        else $error("read stream gap or count skip");

endmodule

bind multi_channel_byte_fifo mcbf_checker u_mcbf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_status     (o_status),
    .o_byte_valid (o_byte_valid),
    .o_moved      (o_moved),
    .o_last       (o_last)
);
